@@ hw/rtl/ted_pkg.sv @@
// Shared types and constants for the touch event decoder.
package ted_pkg;

  localparam int unsigned SWITCH_MAX_DEFAULT = 6;

  localparam logic [7:0] TOUCH_CMD  = 8'hB1;
  localparam logic [7:0] TEMP_LOW   = 8'd100;
  localparam logic [7:0] TEMP_HIGH  = 8'd150;
  localparam logic [7:0] TEMP_RESET = 8'd127;

  localparam logic [3:0] SWITCH_COUNT_RESET = 4'd6;
  localparam logic [7:0] IDLE_LIMIT_RESET   = 8'd200;

  // Touch panel geometry
  localparam logic [15:0] X_TEMP_SPLIT   = 16'd80;
  localparam logic [15:0] X_SWITCH_START = 16'd160;
  localparam logic [15:0] X_COL_SPLIT    = 16'd240;
  localparam logic [15:0] Y_TEMP_START   = 16'd180;
  localparam logic [15:0] Y_ROW_HALF     = 16'd120;
  localparam logic [15:0] Y_ROW_THIRD1   = 16'd80;
  localparam logic [15:0] Y_ROW_THIRD2   = 16'd160;

  // Configuration register indexes
  localparam logic [3:0] CFG_SWITCH_COUNT = 4'd0;
  localparam logic [3:0] CFG_IDLE_LIMIT   = 4'd1;

  // Frame byte positions
  localparam logic [2:0] POS_CMD    = 3'd0;
  localparam logic [2:0] POS_X_HIGH = 3'd1;
  localparam logic [2:0] POS_X_LOW  = 3'd2;
  localparam logic [2:0] POS_Y_HIGH = 3'd3;
  localparam logic [2:0] POS_Y_LOW  = 3'd4;

  typedef enum logic [1:0] {
    EV_TEMP      = 2'd0,
    EV_SWITCH    = 2'd1,
    EV_LIGHT_ON  = 2'd2,
    EV_LIGHT_OFF = 2'd3
  } event_kind_e;

  // Switch zone lookup result
  typedef struct packed {
    logic       hit;
    logic [2:0] idx;
  } zone_t;

endpackage

@@ hw/rtl/ted_zone.sv @@
// Switch zone lookup: maps a touch point to a switch index for the configured layout.
module ted_zone #(
  parameter int unsigned SwitchMax = ted_pkg::SWITCH_MAX_DEFAULT
) (
  input  logic [3:0]    switch_count_i,
  input  logic [15:0]   x_i,
  input  logic [15:0]   y_i,
  output ted_pkg::zone_t zone_o
);

  logic       left;
  logic       in_range;
  logic       hit;
  logic [2:0] idx;

  assign left     = x_i < ted_pkg::X_COL_SPLIT;
  assign in_range = (switch_count_i >= 4'd1) && (switch_count_i <= 4'(SwitchMax));

  always_comb begin
    hit = 1'b1;
    idx = 3'd0;
    case (switch_count_i)
      4'd1: idx = 3'd0;
      4'd2: idx = (y_i < ted_pkg::Y_ROW_HALF) ? 3'd0 : 3'd1;
      4'd3: begin
        if (y_i < ted_pkg::Y_ROW_THIRD1) idx = 3'd0;
        else if (y_i < ted_pkg::Y_ROW_THIRD2) idx = 3'd1;
        else idx = 3'd2;
      end
      4'd4: begin
        if (y_i < ted_pkg::Y_ROW_HALF) idx = left ? 3'd0 : 3'd1;
        else idx = left ? 3'd2 : 3'd3;
      end
      4'd5, 4'd6: begin
        if (y_i < ted_pkg::Y_ROW_THIRD1) idx = left ? 3'd0 : 3'd1;
        else if (y_i < ted_pkg::Y_ROW_THIRD2) idx = left ? 3'd2 : 3'd3;
        else if (left) idx = 3'd4;
        else begin
          idx = 3'd5;
          hit = (switch_count_i == 4'd6);
        end
      end
      default: hit = 1'b0;
    endcase
  end

  assign zone_o.hit = hit && in_range && (idx < 3'(SwitchMax));
  assign zone_o.idx = idx;

endmodule

@@ hw/rtl/touch_event_decoder_unit.sv @@
// Touch event decoder top level: frame assembly, hit test, idle timer, result register.
//
// Decodes touch-controller bytes and idle ticks into UI events. Every word on
// the input channel is captured in an input register; from there it is
// decoded against the block state and any event lands in the output register.
// One word per cycle is sustained: a new word is taken every cycle while the
// output register is empty or being drained. out_valid_o comes from
// the output register and rises when the decoded event is stored there.
// The input stalls only while the input register is full and the output
// register holds an event that the receiver is stalling.
// Frames are five words (command, x high, x low, y high, y low); only command
// 0xB1 acts. Config words (switch_count at index 0, idle_limit at index 1) are
// taken every cycle and should be written while the block is idle.
module touch_event_decoder_unit #(
  parameter int unsigned SwitchMax = ted_pkg::SWITCH_MAX_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input words
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       func_i,
  input  logic [7:0] rx_byte_i,
  // events
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] event_kind_o,
  output logic [7:0] target_value_o,
  output logic [2:0] switch_index_o,
  output logic       switch_on_o,
  // config writes
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [3:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  // ---------------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------------
  logic [3:0] switch_count_q;
  logic [7:0] idle_limit_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      switch_count_q <= ted_pkg::SWITCH_COUNT_RESET;
      idle_limit_q   <= ted_pkg::IDLE_LIMIT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        ted_pkg::CFG_SWITCH_COUNT: switch_count_q <= cfg_data_i[3:0];
        ted_pkg::CFG_IDLE_LIMIT:   idle_limit_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic       in_valid_q;
  logic       func_q;
  logic [7:0] byte_q;
  logic       advance;
  logic       in_take;

  // decode stage moves whenever the output register can take a new event
  assign advance    = !out_valid_o || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      func_q <= func_i;
      byte_q <= rx_byte_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Block state
  // ---------------------------------------------------------------------------
  logic [2:0]           pos_q, pos_d;
  logic [7:0]           cmd_q, cmd_d;
  logic [15:0]          x_q, x_d;
  logic [15:0]          y_q, y_d;
  logic                 light_q, light_d;
  logic [7:0]           idle_q, idle_d;
  logic [7:0]           temp_q, temp_d;
  logic [SwitchMax-1:0] sw_q, sw_d;

  // ---------------------------------------------------------------------------
  // Decode
  // ---------------------------------------------------------------------------
  ted_pkg::zone_t zone;
  logic [15:0]    y_full;
  logic [7:0]     temp_clamp;
  logic [7:0]     temp_step;
  logic           sw_new;
  logic           emit;
  ted_pkg::event_kind_e kind;
  logic [2:0]     ev_idx;
  logic           ev_on;

  // y as it stands once the last frame byte is in
  assign y_full = {y_q[7:0], byte_q};

  ted_zone #(
    .SwitchMax(SwitchMax)
  ) u_zone (
    .switch_count_i(switch_count_q),
    .x_i           (x_q),
    .y_i           (y_full),
    .zone_o        (zone)
  );

  // temperature: clamp into range, then one step toward the touched side
  always_comb begin
    if (temp_q > ted_pkg::TEMP_HIGH) temp_clamp = ted_pkg::TEMP_HIGH;
    else if (temp_q < ted_pkg::TEMP_LOW) temp_clamp = ted_pkg::TEMP_LOW;
    else temp_clamp = temp_q;

    if (x_q >= ted_pkg::X_TEMP_SPLIT && temp_clamp > ted_pkg::TEMP_LOW) begin
      temp_step = temp_clamp - 8'd1;
    end else if (x_q < ted_pkg::X_TEMP_SPLIT && temp_clamp < ted_pkg::TEMP_HIGH) begin
      temp_step = temp_clamp + 8'd1;
    end else begin
      temp_step = temp_clamp;
    end
  end

  always_comb begin
    sw_new = 1'b0;
    for (int k = 0; k < SwitchMax; k++) begin
      if (zone.idx == 3'(k)) sw_new = ~sw_q[k];
    end
  end

  always_comb begin
    pos_d   = pos_q;
    cmd_d   = cmd_q;
    x_d     = x_q;
    y_d     = y_q;
    light_d = light_q;
    idle_d  = idle_q;
    temp_d  = temp_q;
    sw_d    = sw_q;
    emit    = 1'b0;
    kind    = ted_pkg::EV_TEMP;
    ev_idx  = 3'd0;
    ev_on   = 1'b0;

    if (func_q) begin
      // idle tick
      if (light_q) begin
        if (idle_q == idle_limit_q) begin
          light_d = 1'b0;
          emit    = 1'b1;
          kind    = ted_pkg::EV_LIGHT_OFF;
        end else begin
          idle_d = idle_q + 8'd1;
        end
      end
    end else begin
      unique case (pos_q)
        ted_pkg::POS_X_HIGH: begin
          x_d   = {8'd0, byte_q};
          pos_d = ted_pkg::POS_X_LOW;
        end
        ted_pkg::POS_X_LOW: begin
          x_d   = {x_q[7:0], byte_q};
          pos_d = ted_pkg::POS_Y_HIGH;
        end
        ted_pkg::POS_Y_HIGH: begin
          y_d   = {8'd0, byte_q};
          pos_d = ted_pkg::POS_Y_LOW;
        end
        ted_pkg::POS_Y_LOW: begin
          y_d   = y_full;
          pos_d = ted_pkg::POS_CMD;
          if (cmd_q == ted_pkg::TOUCH_CMD) begin
            idle_d = 8'd0;
            if (!light_q) begin
              light_d = 1'b1;
              emit    = 1'b1;
              kind    = ted_pkg::EV_LIGHT_ON;
            end else if (x_q < ted_pkg::X_SWITCH_START) begin
              // left side: temperature buttons below the info area
              if (y_full > ted_pkg::Y_TEMP_START && temp_step != temp_q) begin
                temp_d = temp_step;
                emit   = 1'b1;
                kind   = ted_pkg::EV_TEMP;
              end
            end else if (zone.hit) begin
              for (int k = 0; k < SwitchMax; k++) begin
                if (zone.idx == 3'(k)) sw_d[k] = sw_new;
              end
              emit   = 1'b1;
              kind   = ted_pkg::EV_SWITCH;
              ev_idx = zone.idx;
              ev_on  = sw_new;
            end
          end
        end
        default: begin
          // command byte; unreachable positions also restart here
          cmd_d = byte_q;
          pos_d = ted_pkg::POS_X_HIGH;
        end
      endcase
    end
  end

  logic fire;
  assign fire = in_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= ted_pkg::POS_CMD;
      cmd_q   <= 8'd0;
      x_q     <= 16'd0;
      y_q     <= 16'd0;
      light_q <= 1'b1;
      idle_q  <= 8'd0;
      temp_q  <= ted_pkg::TEMP_RESET;
      sw_q    <= '0;
    end else if (fire) begin
      pos_q   <= pos_d;
      cmd_q   <= cmd_d;
      x_q     <= x_d;
      y_q     <= y_d;
      light_q <= light_d;
      idle_q  <= idle_d;
      temp_q  <= temp_d;
      sw_q    <= sw_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic       out_valid_q;
  logic [1:0] kind_q;
  logic [7:0] target_q;
  logic [2:0] idx_q;
  logic       on_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= fire && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      kind_q   <= kind;
      target_q <= temp_d;
      idx_q    <= ev_idx;
      on_q     <= ev_on;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign event_kind_o   = kind_q;
  assign target_value_o = target_q;
  assign switch_index_o = idx_q;
  assign switch_on_o    = on_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_temp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && event_kind_o == ted_pkg::EV_TEMP) |->
      (target_value_o >= ted_pkg::TEMP_LOW && target_value_o <= ted_pkg::TEMP_HIGH))
    else $error("temperature event outside target range");

  a_switch_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && event_kind_o == ted_pkg::EV_SWITCH) |-> (switch_index_o < 3'(SwitchMax)))
    else $error("switch event index beyond switch count");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= ted_pkg::POS_Y_LOW)
    else $error("frame position out of range");

  a_light_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && emit && kind == ted_pkg::EV_LIGHT_OFF) |=> !light_q)
    else $error("backlight-off event left backlight on");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_o))
    else $error("input stalled with no pending event");

endmodule
